>>> hdl/sintv_pkg.sv
`timescale 1ns / 1ps

package sintv_pkg;

  // Fixed widths of the word fields
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned IDX_W       = 4;
  localparam int unsigned ENTRY_W     = 2 * VAL_W;
  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 72;
  localparam int unsigned OUT_TUSER_W = 3;

  // At most this many entries leave per emission
  localparam int unsigned MAX_EMIT = 16;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_FULL = 2'd1,
    STATUS_BAD  = 2'd2
  } status_e;

  // Controller -> datapath
  typedef struct packed {
    logic load;   // take the input word
    logic scan;   // merge pass, old bank -> new bank
    logic close;  // write pending interval, commit
    logic emit;   // stream table out
    logic empty;  // send the single empty-table word
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic in_bad;       // presented start above end
    logic scan_done;
    logic close_empty;  // table empty after close
    logic emit_done;
    logic out_free;     // output register can take a word
  } sts_t;

endpackage

>>> hdl/sintv_ram.sv
`timescale 1ns / 1ps

module sintv_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/sintv_ctrl.sv
`timescale 1ns / 1ps

module sintv_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  sintv_pkg::sts_t   sts_i,
  output sintv_pkg::cmd_t   cmd_o
);

  import sintv_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_CLOSE = 5'b00100,
    ST_EMIT  = 5'b01000,
    ST_EMPTY = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          // bad interval skips the merge pass
          state_d = sts_i.in_bad ? ST_CLOSE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = ST_CLOSE;
        end
      end
      ST_CLOSE: begin
        cmd_o.close = 1'b1;
        state_d = sts_i.close_empty ? ST_EMPTY : ST_EMIT;
      end
      ST_EMIT: begin
        cmd_o.emit = 1'b1;
        if (sts_i.emit_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_EMPTY: begin
        cmd_o.empty = 1'b1;
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> hdl/sintv_dp.sv
`timescale 1ns / 1ps

module sintv_dp #(
  parameter int unsigned MAX_INTERVALS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  sintv_pkg::cmd_t                       cmd_i,
  output sintv_pkg::sts_t                       sts_o,
  input  logic [sintv_pkg::VAL_W-1:0]           in_start_i,
  input  logic [sintv_pkg::VAL_W-1:0]           in_end_i,
  input  logic                                  in_clear_i,
  input  logic                                  m_ready_i,
  output logic                                  m_valid_o,
  output logic [sintv_pkg::OUT_TDATA_W-1:0]     m_data_o,
  output logic                                  m_last_o,
  output logic [sintv_pkg::OUT_TUSER_W-1:0]     m_user_o
);

  import sintv_pkg::*;

  localparam int unsigned CntW    = $clog2(MAX_INTERVALS + 2);
  localparam int unsigned AddrW   = $clog2(MAX_INTERVALS);
  localparam int unsigned EmitLim = (MAX_INTERVALS < MAX_EMIT) ? MAX_INTERVALS : MAX_EMIT;
  localparam int unsigned PadW    = OUT_TDATA_W - ENTRY_W - IDX_W;

  // control state
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] rd_idx_q, rd_idx_d;
  logic [CntW-1:0] wr_idx_q, wr_idx_d;
  logic            bank_q, bank_d;
  logic            rd_vld_q, rd_vld_d;
  logic            ins_q, ins_d;
  logic            out_vld_q, out_vld_d;

  // payload
  logic [CntW-1:0]  rd_pos_q, rd_pos_d;
  logic [VAL_W-1:0] ns_q, ns_d, ne_q, ne_d, ms_q, ms_d, me_q, me_d;
  logic             bad_q, bad_d;
  status_e          status_q, status_d;
  logic [VAL_W-1:0] out_start_q, out_start_d, out_end_q, out_end_d;
  logic [IDX_W-1:0] out_idx_q, out_idx_d;
  logic             out_last_q, out_last_d, out_empty_q, out_empty_d;
  status_e          out_status_q, out_status_d;

  // memory ports
  logic               we, want_wr, re;
  logic [ENTRY_W-1:0] wdata, rdata0, rdata1, rdata;
  logic [VAL_W-1:0]   rd_s, rd_e;

  logic [CntW-1:0] lim, n_emit, fin_cnt;
  logic is_before, is_overlap, hold, out_free, consume, issue, load_out;

  assign rdata = bank_q ? rdata1 : rdata0;
  assign rd_s  = rdata[VAL_W-1:0];
  assign rd_e  = rdata[ENTRY_W-1:VAL_W];

  assign n_emit  = (count_q > CntW'(EmitLim)) ? CntW'(EmitLim) : count_q;
  assign lim     = cmd_i.scan ? count_q : n_emit;
  assign fin_cnt = wr_idx_q + CntW'(!ins_q);

  // classify the stored entry against the incoming interval
  assign is_before  = rd_e < ns_q;
  assign is_overlap = !is_before && (rd_s <= ne_q);
  assign hold       = !is_before && !is_overlap && !ins_q;

  assign out_free = !out_vld_q || m_ready_i;
  assign consume  = rd_vld_q && (cmd_i.scan ? !hold : (cmd_i.emit && out_free));
  assign issue    = (cmd_i.scan || cmd_i.emit) && (rd_idx_q < lim) && (consume || !rd_vld_q);
  assign re       = issue;
  assign load_out = (cmd_i.emit && consume) || (cmd_i.empty && out_free);
  assign we       = want_wr && (wr_idx_q < CntW'(MAX_INTERVALS));

  always_comb begin
    count_d  = count_q;
    rd_idx_d = rd_idx_q;
    wr_idx_d = wr_idx_q;
    bank_d   = bank_q;
    rd_vld_d = rd_vld_q;
    ins_d    = ins_q;
    rd_pos_d = rd_pos_q;
    ns_d     = ns_q;
    ne_d     = ne_q;
    ms_d     = ms_q;
    me_d     = me_q;
    bad_d    = bad_q;
    status_d = status_q;
    want_wr  = 1'b0;
    wdata    = {me_q, ms_q};

    if (cmd_i.load) begin
      ns_d     = in_start_i;
      ne_d     = in_end_i;
      ms_d     = in_start_i;
      me_d     = in_end_i;
      bad_d    = in_start_i > in_end_i;
      rd_idx_d = '0;
      wr_idx_d = '0;
      ins_d    = 1'b0;
      rd_vld_d = 1'b0;
      if (in_clear_i) begin
        count_d = '0;
      end
    end

    if (cmd_i.scan && rd_vld_q) begin
      priority if (is_before) begin
        want_wr = 1'b1;
        wdata   = rdata;
      end else if (is_overlap) begin
        ms_d = (rd_s < ms_q) ? rd_s : ms_q;
        me_d = (rd_e > me_q) ? rd_e : me_q;
      end else if (!ins_q) begin
        // merged interval goes first, entry is held for the next cycle
        want_wr = 1'b1;
        ins_d   = 1'b1;
      end else begin
        want_wr = 1'b1;
        wdata   = rdata;
      end
      if (want_wr) begin
        wr_idx_d = wr_idx_q + CntW'(1);
      end
    end

    if (cmd_i.close) begin
      rd_idx_d = '0;
      if (bad_q) begin
        status_d = STATUS_BAD;
      end else begin
        want_wr = !ins_q;
        if (fin_cnt == CntW'(MAX_INTERVALS + 1)) begin
          status_d = STATUS_FULL;
        end else begin
          status_d = STATUS_OK;
          bank_d   = !bank_q;
          count_d  = fin_cnt;
        end
      end
    end

    if (issue) begin
      rd_idx_d = rd_idx_q + CntW'(1);
      rd_pos_d = rd_idx_q;
      rd_vld_d = 1'b1;
    end else if (consume) begin
      rd_vld_d = 1'b0;
    end
  end

  // output register
  always_comb begin
    out_vld_d    = out_vld_q;
    out_start_d  = out_start_q;
    out_end_d    = out_end_q;
    out_idx_d    = out_idx_q;
    out_last_d   = out_last_q;
    out_empty_d  = out_empty_q;
    out_status_d = out_status_q;
    if (out_vld_q && m_ready_i) begin
      out_vld_d = 1'b0;
    end
    if (load_out) begin
      out_vld_d    = 1'b1;
      out_status_d = status_q;
      if (cmd_i.empty) begin
        out_start_d = '0;
        out_end_d   = '0;
        out_idx_d   = '0;
        out_last_d  = 1'b1;
        out_empty_d = 1'b1;
      end else begin
        out_start_d = rd_s;
        out_end_d   = rd_e;
        out_idx_d   = IDX_W'(rd_pos_q);
        out_last_d  = rd_pos_q == (n_emit - CntW'(1));
        out_empty_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      rd_idx_q  <= '0;
      wr_idx_q  <= '0;
      bank_q    <= 1'b0;
      rd_vld_q  <= 1'b0;
      ins_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      rd_idx_q  <= rd_idx_d;
      wr_idx_q  <= wr_idx_d;
      bank_q    <= bank_d;
      rd_vld_q  <= rd_vld_d;
      ins_q     <= ins_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_pos_q     <= rd_pos_d;
    ns_q         <= ns_d;
    ne_q         <= ne_d;
    ms_q         <= ms_d;
    me_q         <= me_d;
    bad_q        <= bad_d;
    status_q     <= status_d;
    out_start_q  <= out_start_d;
    out_end_q    <= out_end_d;
    out_idx_q    <= out_idx_d;
    out_last_q   <= out_last_d;
    out_empty_q  <= out_empty_d;
    out_status_q <= out_status_d;
  end

  // ping-pong banks: read the active one, build the new table in the other
  sintv_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_INTERVALS)
  ) u_bank0 (
    .clk_i   (clk_i),
    .we_i    (we && bank_q),
    .waddr_i (wr_idx_q[AddrW-1:0]),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (rd_idx_q[AddrW-1:0]),
    .rdata_o (rdata0)
  );

  sintv_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_INTERVALS)
  ) u_bank1 (
    .clk_i   (clk_i),
    .we_i    (we && !bank_q),
    .waddr_i (wr_idx_q[AddrW-1:0]),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (rd_idx_q[AddrW-1:0]),
    .rdata_o (rdata1)
  );

  assign sts_o.in_bad      = in_start_i > in_end_i;
  assign sts_o.scan_done   = (rd_idx_q == count_q) && !rd_vld_q;
  assign sts_o.close_empty = bad_q && (count_q == '0);
  assign sts_o.emit_done   = (rd_idx_q == n_emit) && !rd_vld_q;
  assign sts_o.out_free    = out_free;

  assign m_valid_o = out_vld_q;
  assign m_data_o  = {{PadW{1'b0}}, out_idx_q, out_end_q, out_start_q};
  assign m_last_o  = out_last_q;
  assign m_user_o  = {out_empty_q, out_status_q};

endmodule

>>> hdl/sorted_interval_insert_merge_core.sv
`timescale 1ns / 1ps

// Sorted interval table with insert and merge.
// Slave stream: one word is one closed interval [start, end]; tuser asks to
// empty the table first. The interval is merged with every stored entry it
// overlaps or touches, or inserted in order; a start above its end, or a full
// table with no merge, drops it (status 2 / 1) and the table stays as it was.
// Master stream: after every input the table goes out in order, one word per
// entry (at most 16), tlast on the final one. An empty table gives one word
// with the table-empty flag set and zero interval fields.
// Timing: a table of N entries is rebuilt in a merge pass (one entry per cycle
// through the read port of the table memory, with a pause while the pending
// interval is written ahead of a later entry), committed, then streamed at one
// word per cycle while the receiver is ready. One input is in work at a time.
// The last result sits in the output register while the next word is taken.
// A stalled receiver holds the output register and pauses the memory reads.
// Reset empties the table at once; no clearing pass is run.
module sorted_interval_insert_merge_core #(
  parameter int unsigned MAX_INTERVALS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // [31:0] new_start, [63:32] new_end
  input  logic        s_axis_tuser,  // [0] clear_first
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // [31:0] out_start, [63:32] out_end,
                                     // [67:64] entry_index, [71:68] zero
  output logic        m_axis_tlast,  // last_entry
  output logic [2:0]  m_axis_tuser   // [1:0] status, [2] table_empty
);

  import sintv_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: idle -> merge pass (skipped for a bad interval) -> commit -> emission or empty-table word
  sintv_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // table banks, merge compare, counters and output register
  sintv_dp #(
    .MAX_INTERVALS (MAX_INTERVALS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_start_i (s_axis_tdata[VAL_W-1:0]),
    .in_end_i   (s_axis_tdata[IN_TDATA_W-1:VAL_W]),
    .in_clear_i (s_axis_tuser),
    .m_ready_i  (m_axis_tready),
    .m_valid_o  (m_axis_tvalid),
    .m_data_o   (m_axis_tdata),
    .m_last_o   (m_axis_tlast),
    .m_user_o   (m_axis_tuser)
  );

  // one command at a time from the sequencer
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd))
    else $error("sequencer issued overlapping commands");

  // a taken word starts work; no second word until the emission is done
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while an item is in work");

  // the empty-table word is a lone last word with zero fields
  a_empty_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[2]) |->
      (m_axis_tlast && m_axis_tdata == '0))
    else $error("empty-table word malformed");

  // status code 3 is never produced
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser[1:0] != 2'b11))
    else $error("undefined status on output");

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import sintv_pkg::*;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned RAND_ITEMS  = 500;
  localparam int unsigned HOLD_AT     = 420;    // intervals in before the long output stall
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_LIMIT = 20000;

  // One emitted table word as the block should send it
  typedef struct {
    logic [31:0] iv_start;
    logic [31:0] iv_stop;
    logic [3:0]  idx;
    logic        last;
    status_e     status;
    logic        empty;
  } table_word_t;

  // Shadow copy of the interval table plus the words it still owes
  class interval_table_board;
    logic [31:0]  starts[TABLE_DEPTH];
    logic [31:0]  stops[TABLE_DEPTH];
    int unsigned  used;
    table_word_t  pending_words[$];
    int unsigned  error_count;

    function new();
      used        = 0;
      error_count = 0;
    endfunction

    // Insert or merge one well-formed interval, return the outcome
    function status_e merge_interval(logic [31:0] ns, logic [31:0] ne);
      int unsigned lo, hi, gap, k;
      logic [31:0] ms, me;
      lo = 0;
      while (lo < used && stops[lo] < ns) lo++;
      hi = lo;
      while (hi < used && starts[hi] <= ne) hi++;
      if (hi == lo) begin
        if (used >= TABLE_DEPTH) return STATUS_FULL;
        for (k = used; k > lo; k--) begin
          starts[k] = starts[k-1];
          stops[k]  = stops[k-1];
        end
        starts[lo] = ns;
        stops[lo]  = ne;
        used++;
        return STATUS_OK;
      end
      // entries lo..hi-1 collapse into lo, the tail closes up
      ms  = (starts[lo] < ns) ? starts[lo] : ns;
      me  = (stops[hi-1] > ne) ? stops[hi-1] : ne;
      gap = hi - lo - 1;
      starts[lo] = ms;
      stops[lo]  = me;
      for (k = hi; k < used; k++) begin
        starts[k-gap] = starts[k];
        stops[k-gap]  = stops[k];
      end
      used -= gap;
      return STATUS_OK;
    endfunction

    // Accepted input word: update the table, queue the emission it causes
    function void take_interval(logic [31:0] ns, logic [31:0] ne, logic clr);
      status_e     st;
      int unsigned n, k;
      table_word_t w;
      if (clr) used = 0;
      if (ns > ne) st = STATUS_BAD;
      else st = merge_interval(ns, ne);
      if (used == 0) begin
        w.iv_start = '0;
        w.iv_stop  = '0;
        w.idx      = '0;
        w.last     = 1'b1;
        w.status   = st;
        w.empty    = 1'b1;
        pending_words = {pending_words, w};
      end else begin
        n = (used < MAX_EMIT) ? used : MAX_EMIT;
        for (k = 0; k < n; k++) begin
          w.iv_start = starts[k];
          w.iv_stop  = stops[k];
          w.idx      = k[3:0];
          w.last     = (k + 1 == n);
          w.status   = st;
          w.empty    = 1'b0;
          pending_words = {pending_words, w};
        end
      end
    endfunction

    // Accepted output word against the oldest expectation
    function void check_word(logic [71:0] data, logic last, logic [2:0] user);
      table_word_t w;
      logic        bad;
      if (pending_words.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("%0t: unexpected word start=%h end=%h idx=%0d last=%b user=%b",
                   $realtime, data[31:0], data[63:32], data[67:64], last, user);
        return;
      end
      w   = pending_words.pop_front();
      bad = (data[31:0] !== w.iv_start) || (data[63:32] !== w.iv_stop) ||
            (data[67:64] !== w.idx) || (data[71:68] !== 4'd0) ||
            (last !== w.last) || (user[1:0] !== w.status) || (user[2] !== w.empty);
      if (bad) begin
        error_count++;
        if (error_count <= 10) begin
          $display("%0t: word mismatch", $realtime);
          $display("  expected start=%h end=%h idx=%0d last=%b status=%0d empty=%b pad=0",
                   w.iv_start, w.iv_stop, w.idx, w.last, w.status, w.empty);
          $display("  got      start=%h end=%h idx=%0d last=%b status=%0d empty=%b pad=%h",
                   data[31:0], data[63:32], data[67:64], last, user[1:0], user[2],
                   data[71:68]);
        end
      end
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic [2:0]  m_axis_tuser;

  interval_table_board board;
  int unsigned tx_idle_pct    = 15;
  int unsigned rx_idle_pct    = 62;
  int unsigned intervals_sent = 0;
  logic        rx_hold        = 1'b0;

  sorted_interval_insert_merge_core #(
    .MAX_INTERVALS(TABLE_DEPTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #4 clk_i = ~clk_i;

  // Receiver: random back-pressure, forced low during the hold-off
  always @(posedge clk_i) begin
    m_axis_tready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_word(m_axis_tdata, m_axis_tlast, m_axis_tuser);
  end

  // Long output stall while the sender keeps offering; input must back up
  initial begin : rx_hold_off
    int unsigned n;
    wait (intervals_sent >= HOLD_AT);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Offer one interval word, return at the edge it is taken
  task automatic send_interval(input logic [31:0] iv_start, input logic [31:0] iv_stop,
                               input logic clr);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {iv_stop, iv_start};
    s_axis_tuser  <= clr;
    do @(posedge clk_i); while (!s_axis_tready);
    board.take_interval(iv_start, iv_stop, clr);
    intervals_sent++;
  endtask

  initial begin : stimulus
    int unsigned i, r, span, base, cycles;
    logic [31:0] a, b, offs;
    logic        clr;
    board = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, bad interval, extremes, touching merge, clear
    send_interval(32'd5, 32'd10, 1'b0);
    send_interval(32'd7, 32'd3, 1'b0);
    send_interval(32'd0, 32'd0, 1'b0);
    send_interval(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_interval(32'd10, 32'd20, 1'b0);                 // shares endpoint 10
    send_interval(32'hFFFF_FFFF, 32'd0, 1'b1);           // clear, then dropped: empty
    // fill to capacity, then a non-merging drop, a double merge, a full span
    for (i = 0; i < TABLE_DEPTH; i++)
      send_interval(i * 10, i * 10 + 3, i == 0);
    send_interval(32'd500, 32'd600, 1'b0);
    send_interval(32'd3, 32'd10, 1'b0);
    send_interval(32'd0, 32'hFFFF_FFFF, 1'b0);

    for (i = 0; i < RAND_ITEMS; i++) begin
      if (i == RAND_ITEMS / 3) begin
        tx_idle_pct = 62;
        rx_idle_pct = 15;
      end else if (i == 2 * RAND_ITEMS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      r   = $urandom_range(0, 99);
      clr = ($urandom_range(0, 39) == 0);
      if (r < 70) begin
        // short intervals in a narrow window so the table fills and merges
        offs = ($urandom_range(0, 4) == 0) ? 32'hFFFF_FFFF - 32'd1200 : 32'd0;
        base = $urandom_range(0, 1023);
        span = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 80) : $urandom_range(0, 12);
        a = offs + base;
        b = a + span;
      end else if (r < 80) begin
        a = $urandom;
        b = $urandom;
        if (a < b) {a, b} = {b, a};
      end else if (r < 90) begin
        a = $urandom;
        b = $urandom;
        if (a > b) {a, b} = {b, a};
      end else begin
        a   = $urandom;
        b   = $urandom;
        clr = 1'($urandom_range(0, 1));
      end
      send_interval(a, b, clr);
    end
    s_axis_tvalid <= 1'b0;

    cycles = 0;
    while (board.pending_words.size() != 0 && cycles < DRAIN_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    repeat (60) @(posedge clk_i);
    if (board.pending_words.size() != 0) begin
      board.error_count += board.pending_words.size();
      $display("%0d expected words never arrived", board.pending_words.size());
    end
    if (board.error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
